>>> design/assert_macros.svh
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion checked on rising clk, disabled in reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion checked on rising clk, active during reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/pcmf_pkg.sv
// ----------------------------------------------------------------------------
// pcmf_pkg
// Formats, register indexes and the integer to float32 conversion function.
// ----------------------------------------------------------------------------
package pcmf_pkg;

  typedef enum logic [2:0] {
    FMT_U8     = 3'd0,
    FMT_S8     = 3'd1,
    FMT_U16_BE = 3'd2,
    FMT_S16_BE = 3'd3,
    FMT_U16_LE = 3'd4,
    FMT_S16_LE = 3'd5,
    FMT_F32_BE = 3'd6,
    FMT_NONE   = 3'd7
  } fmt_t;

  localparam logic CFG_FORMAT = 1'b0;
  localparam logic CFG_REPEAT = 1'b1;
  localparam int   CFG_DATA_W = 4;

  localparam logic [2:0] FORMAT_RESET = 3'd5;
  localparam logic [3:0] REPEAT_RESET = 4'd2;

  // Converted sample handed from the assembly stage to the output stage.
  typedef struct packed {
    logic [31:0] bits;
  } sample_t;

  // Signed 16-bit value v (8-bit values pre-shifted left by 8) to float32 of
  // v/32768. Exact: result = sign, exponent from leading one, mantissa.
  function automatic logic [31:0] s16_to_f32(input logic [15:0] v);
    logic        sgn;
    logic [15:0] mag;
    logic [4:0]  lead;
    logic [7:0]  expo;
    logic [22:0] man;
    logic [15:0] shifted;
    sgn  = v[15];
    mag  = sgn ? (16'd0 - v) : v;
    lead = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) lead = 5'(i);
    end
    shifted = mag << (5'd15 - lead);
    man  = {shifted[14:0], 8'd0};
    // value = mag * 2^-15, leading one at lead -> exponent lead-15+127
    expo = 8'(lead) + 8'd112;
    if (mag == 16'd0) s16_to_f32 = 32'd0;
    else s16_to_f32 = {sgn, expo, man};
  endfunction

endpackage

>>> design/pcmf_stream_if.sv
// ----------------------------------------------------------------------------
// pcmf_stream_if
// Valid/ready channel carrying a parameterized payload.
// ----------------------------------------------------------------------------
interface pcmf_stream_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/pcm_to_float_sample_converter.sv
// Converts a PCM byte stream into IEEE single-precision samples. One byte is
// accepted per cycle while the output stage can take a finished sample; a
// completed sample is shown repeat_count times (capped at MAX_REPEAT) by the
// single output register that replays the copies.
// ----------------------------------------------------------------------------
// pcm_to_float_sample_converter
// Byte assembly, format conversion and repeated sample output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcm_to_float_sample_converter #(
  parameter int MAX_REPEAT = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  pcmf_stream_if.sink                       in_bytes,
  pcmf_stream_if.source                     out_samples,
  output logic                              out_last_copy,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [pcmf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_REPEAT + 1);

  logic [2:0]  sample_format;
  logic [3:0]  repeat_count;
  logic [23:0] partial_sample;
  logic [1:0]  byte_phase;

  logic [1:0]  need_m1;
  logic        fmt_ok;
  logic        free;
  logic        take;
  logic        done;
  logic [31:0] word;
  logic [15:0] v16;
  pcmf_pkg::sample_t conv;
  logic [CW-1:0] copies;
  logic [31:0] out_bits;

  always_comb begin
    case (pcmf_pkg::fmt_t'(sample_format))
      pcmf_pkg::FMT_U8, pcmf_pkg::FMT_S8: begin need_m1 = 2'd0; fmt_ok = 1'b1; end
      pcmf_pkg::FMT_F32_BE:               begin need_m1 = 2'd3; fmt_ok = 1'b1; end
      pcmf_pkg::FMT_NONE:                 begin need_m1 = 2'd0; fmt_ok = 1'b0; end
      default:                            begin need_m1 = 2'd1; fmt_ok = 1'b1; end
    endcase
  end

  assign in_bytes.ready = free;
  assign take = in_bytes.valid && free;
  assign done = fmt_ok && (byte_phase == need_m1);
  assign word = {partial_sample, in_bytes.data};

  always_comb begin
    case (pcmf_pkg::fmt_t'(sample_format))
      pcmf_pkg::FMT_U8:     v16 = {word[7:0] ^ 8'h80, 8'd0};
      pcmf_pkg::FMT_S8:     v16 = {word[7:0], 8'd0};
      pcmf_pkg::FMT_U16_BE: v16 = word[15:0] ^ 16'h8000;
      pcmf_pkg::FMT_S16_BE: v16 = word[15:0];
      pcmf_pkg::FMT_U16_LE: v16 = {word[7:0], word[15:8]} ^ 16'h8000;
      pcmf_pkg::FMT_S16_LE: v16 = {word[7:0], word[15:8]};
      default:              v16 = 16'd0;
    endcase
    conv.bits = (pcmf_pkg::fmt_t'(sample_format) == pcmf_pkg::FMT_F32_BE) ?
                word : pcmf_pkg::s16_to_f32(v16);
    copies = (32'(repeat_count) > MAX_REPEAT) ? CW'(MAX_REPEAT) : CW'(repeat_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format  <= pcmf_pkg::FORMAT_RESET;
      repeat_count   <= pcmf_pkg::REPEAT_RESET;
      partial_sample <= '0;
      byte_phase     <= '0;
    end else if (cfg_we) begin
      if (cfg_index == pcmf_pkg::CFG_FORMAT) begin
        sample_format  <= cfg_data[2:0];
        partial_sample <= '0;
        byte_phase     <= '0;
      end else begin
        repeat_count <= cfg_data;
      end
    end else if (take) begin
      if (!fmt_ok || done) begin
        partial_sample <= '0;
        byte_phase     <= '0;
      end else begin
        partial_sample <= word[23:0];
        byte_phase     <= byte_phase + 2'd1;
      end
    end
  end

  pcmf_out_stage #(.CW(CW)) u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (take && done),
    .sample        (conv),
    .copies        (copies),
    .busy_next_free(free),
    .out_ready     (out_samples.ready),
    .out_valid     (out_samples.valid),
    .out_bits      (out_bits),
    .out_last      (out_last_copy)
  );

  assign out_samples.data = out_bits;

  `ASSERT_CLK(a_phase_range, clk, rst, byte_phase <= need_m1 || !fmt_ok || $past(cfg_we),
    "byte phase beyond sample size")
  `ASSERT_CLK(a_none_idle, clk, rst, (sample_format == pcmf_pkg::FMT_NONE) |-> (byte_phase == 2'd0),
    "unused format holds bytes")
  `ASSERT_CLK(a_last_valid, clk, rst, out_last_copy |-> out_samples.valid,
    "last flag without sample")

endmodule

>>> design/pcmf_out_stage.sv
// ----------------------------------------------------------------------------
// pcmf_out_stage
// Holds one converted sample and emits it repeat times, flagging the last.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcmf_out_stage #(
  parameter int CW = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  pcmf_pkg::sample_t     sample,
  input  logic [CW-1:0]         copies,
  output logic                  busy_next_free,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [31:0]           out_bits,
  output logic                  out_last
);

  logic [CW-1:0]     left;
  pcmf_pkg::sample_t held;
  logic              fire;

  assign out_valid      = (left != '0);
  assign fire           = out_valid && out_ready;
  // free for a new sample when empty or sending the final copy now
  assign busy_next_free = !out_valid || (fire && left == CW'(1));
  assign out_bits       = held.bits;
  assign out_last       = (left == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (load) begin
      left <= copies;
    end else if (fire) begin
      left <= left - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= sample;
    end
  end

  `ASSERT_CLK(a_load_free, clk, rst, load |-> busy_next_free, "load while busy")
  `ASSERT_CLK(a_hold, clk, rst, (out_valid && !out_ready) |=> $stable(out_bits),
    "held sample changed under stall")
  `ASSERT_ALWAYS(a_rst_empty, clk, $past(rst) |-> !out_valid, "valid after reset")

endmodule
